// ===== rtl/pasm_pkg.sv =====
`default_nettype none
package pasm_pkg;

    // Sizing of the coefficient stores and the result words.
    localparam int MAX_DEGREE = 15;
    localparam int COEFF_BITS = 16;
    localparam int IN_BITS    = 16;
    localparam int STORE_W    = (COEFF_BITS < IN_BITS) ? COEFF_BITS : IN_BITS;
    localparam int DEPTH      = MAX_DEGREE + 1;
    localparam int IDX_W      = 4;
    localparam int POW_W      = 5;
    localparam int VALUE_W    = 36;
    localparam int PROD_W     = 2 * STORE_W;

    // Operation codes of an input word.
    localparam logic [1:0] OP_LOAD_A  = 2'd0;
    localparam logic [1:0] OP_LOAD_B  = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_SUM  = 2'd0;
    localparam logic [1:0] KIND_DIFF = 2'd1;
    localparam logic [1:0] KIND_PROD = 2'd2;

    // Configuration register indexes.
    localparam logic REG_DEGREE_A = 1'b0;
    localparam logic REG_DEGREE_B = 1'b1;

    // One step issued by the controller to the datapath.
    typedef struct packed {
        logic             valid;
        logic [1:0]       kind;
        logic [POW_W-1:0] power;
        logic [IDX_W-1:0] addr_a;
        logic [IDX_W-1:0] addr_b;
        logic             use_a;
        logic             use_b;
        logic             first;
        logic             fin;
        logic             last;
    } pasm_cmd_t;

    // Coefficient store write.
    typedef struct packed {
        logic               en_a;
        logic               en_b;
        logic [IDX_W-1:0]   addr;
        logic [STORE_W-1:0] data;
    } pasm_wr_t;

endpackage
`default_nettype wire

// ===== rtl/pasm_dp.sv =====
`default_nettype none
module pasm_dp (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire pasm_pkg::pasm_wr_t                 wr,
    input  wire pasm_pkg::pasm_cmd_t                cmd,
    output logic                                    active,
    output logic                                    result_valid,
    output logic [1:0]                              result_kind,
    output logic [pasm_pkg::POW_W-1:0]              power,
    output logic signed [pasm_pkg::VALUE_W-1:0]     value,
    output logic                                    last
);

    localparam int SW = pasm_pkg::STORE_W;
    localparam int VW = pasm_pkg::VALUE_W;
    localparam int PW = pasm_pkg::PROD_W;

    logic [SW-1:0] mem_a [pasm_pkg::DEPTH];
    logic [SW-1:0] mem_b [pasm_pkg::DEPTH];

    logic [SW-1:0]        rd_a_reg, rd_b_reg;
    pasm_pkg::pasm_cmd_t  cmd1_reg, cmd2_reg;
    logic signed [SW-1:0] a1_reg, b1_reg, a1_next, b1_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [VW-1:0] acc_reg, acc_next;
    logic signed [VW-1:0] a_w, b_w, p_w, val_next;

    logic                 result_valid_reg;
    logic [1:0]           result_kind_reg;
    logic [pasm_pkg::POW_W-1:0] power_reg;
    logic signed [VW-1:0] value_reg;
    logic                 last_reg;

    // Stores: one write and one registered read per cycle each.
    always_ff @(posedge clk)
    begin
        if (wr.en_a)
        begin
            mem_a[wr.addr] <= wr.data;
        end
        if (wr.en_b)
        begin
            mem_b[wr.addr] <= wr.data;
        end
        rd_a_reg <= mem_a[cmd.addr_a];
        rd_b_reg <= mem_b[cmd.addr_b];
    end

    always_comb
    begin
        a1_next   = cmd1_reg.use_a ? $signed(rd_a_reg) : '0;
        b1_next   = cmd1_reg.use_b ? $signed(rd_b_reg) : '0;
        prod_next = a1_next * b1_next;
    end

    always_comb
    begin
        a_w      = {{(VW-SW){a1_reg[SW-1]}}, a1_reg};
        b_w      = {{(VW-SW){b1_reg[SW-1]}}, b1_reg};
        p_w      = {{(VW-PW){prod_reg[PW-1]}}, prod_reg};
        acc_next = cmd2_reg.first ? p_w : acc_reg + p_w;
        unique case (cmd2_reg.kind)
            pasm_pkg::KIND_SUM:  val_next = a_w + b_w;
            pasm_pkg::KIND_DIFF: val_next = b_w - a_w;
            default:             val_next = acc_next;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd1_reg         <= '0;
            cmd2_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            cmd1_reg         <= cmd;
            cmd2_reg         <= cmd1_reg;
            result_valid_reg <= cmd2_reg.valid && cmd2_reg.fin;
        end
    end

    always_ff @(posedge clk)
    begin
        a1_reg   <= a1_next;
        b1_reg   <= b1_next;
        prod_reg <= prod_next;
        if (cmd2_reg.valid && cmd2_reg.kind == pasm_pkg::KIND_PROD)
        begin
            acc_reg <= acc_next;
        end
        if (cmd2_reg.valid && cmd2_reg.fin)
        begin
            result_kind_reg <= cmd2_reg.kind;
            power_reg       <= cmd2_reg.power;
            value_reg       <= val_next;
            last_reg        <= cmd2_reg.last;
        end
    end

    assign active       = cmd1_reg.valid || cmd2_reg.valid;
    assign result_valid = result_valid_reg;
    assign result_kind  = result_kind_reg;
    assign power        = power_reg;
    assign value        = value_reg;
    assign last         = last_reg;

    a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> $past(cmd2_reg.valid && cmd2_reg.fin))
        else $error("result strobe without a finished step");

    a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd1_reg.valid |=> cmd2_reg.valid)
        else $error("step lost between pipeline stages");

    a_last_prod: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && last_reg |-> result_kind_reg == pasm_pkg::KIND_PROD)
        else $error("last flag on a word outside the product run");

endmodule
`default_nettype wire

// ===== rtl/pasm_ctrl.sv =====
`default_nettype none
module pasm_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [1:0]                  operation,
    input  wire logic [pasm_pkg::IDX_W-1:0]  coeff_index,
    input  wire logic signed [15:0]          coeff_value,
    input  wire logic                        cfg_valid,
    input  wire logic                        cfg_index,
    input  wire logic [3:0]                  cfg_data,
    input  wire logic                        dp_active,
    output logic                             busy,
    output logic                             cfg_ready,
    output pasm_pkg::pasm_wr_t               wr,
    output pasm_pkg::pasm_cmd_t              cmd
);

    localparam int PW = pasm_pkg::POW_W;
    localparam logic [PW-1:0] MAXD = PW'(pasm_pkg::MAX_DEGREE);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_DIFF,
        S_PROD,
        S_DRAIN
    } state_t;

    state_t              state_reg, state_next;
    logic [PW-1:0]       p_reg, p_next;
    logic [pasm_pkg::IDX_W-1:0] j_reg, j_next;
    pasm_pkg::pasm_cmd_t cmd_reg, cmd_next;
    logic [3:0]          degree_a_reg, degree_b_reg;

    logic [PW-1:0] da, db, top, pmax, p_inc, pj, jlo, jhi, jlo_inc;
    logic          accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_a_reg <= '0;
            degree_b_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pasm_pkg::REG_DEGREE_A: degree_a_reg <= cfg_data;
                default:                degree_b_reg <= cfg_data;
            endcase
        end
    end

    always_comb
    begin
        da      = ({1'b0, degree_a_reg} > MAXD) ? MAXD : {1'b0, degree_a_reg};
        db      = ({1'b0, degree_b_reg} > MAXD) ? MAXD : {1'b0, degree_b_reg};
        top     = (da > db) ? da : db;
        pmax    = da + db;
        p_inc   = p_reg + 1'b1;
        pj      = p_reg - {1'b0, j_reg};
        jlo     = (p_reg > db) ? p_reg - db : '0;
        jhi     = (p_reg < da) ? p_reg : da;
        jlo_inc = (p_inc > db) ? p_inc - db : '0;
    end

    assign accept = start && !busy;

    always_comb
    begin
        wr.addr = coeff_index;
        wr.data = coeff_value[pasm_pkg::STORE_W-1:0];
        wr.en_a = accept && operation == pasm_pkg::OP_LOAD_A
                  && {1'b0, coeff_index} <= MAXD;
        wr.en_b = accept && operation == pasm_pkg::OP_LOAD_B
                  && {1'b0, coeff_index} <= MAXD;
    end

    always_comb
    begin
        state_next = state_reg;
        p_next     = p_reg;
        j_next     = j_reg;
        cmd_next   = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && operation == pasm_pkg::OP_COMPUTE)
                begin
                    state_next = S_SUM;
                    p_next     = '0;
                end
            end
            S_SUM, S_DIFF:
            begin
                cmd_next.valid  = 1'b1;
                cmd_next.kind   = (state_reg == S_SUM) ? pasm_pkg::KIND_SUM
                                                       : pasm_pkg::KIND_DIFF;
                cmd_next.power  = p_reg;
                cmd_next.addr_a = p_reg[pasm_pkg::IDX_W-1:0];
                cmd_next.addr_b = p_reg[pasm_pkg::IDX_W-1:0];
                cmd_next.use_a  = p_reg <= da;
                cmd_next.use_b  = p_reg <= db;
                cmd_next.first  = 1'b1;
                cmd_next.fin    = 1'b1;
                if (p_reg == top)
                begin
                    p_next     = '0;
                    j_next     = '0;
                    state_next = (state_reg == S_SUM) ? S_DIFF : S_PROD;
                end
                else
                begin
                    p_next = p_inc;
                end
            end
            S_PROD:
            begin
                cmd_next.valid  = 1'b1;
                cmd_next.kind   = pasm_pkg::KIND_PROD;
                cmd_next.power  = p_reg;
                cmd_next.addr_a = j_reg;
                cmd_next.addr_b = pj[pasm_pkg::IDX_W-1:0];
                cmd_next.use_a  = 1'b1;
                cmd_next.use_b  = 1'b1;
                cmd_next.first  = {1'b0, j_reg} == jlo;
                cmd_next.fin    = {1'b0, j_reg} == jhi;
                cmd_next.last   = ({1'b0, j_reg} == jhi) && (p_reg == pmax);
                if ({1'b0, j_reg} == jhi)
                begin
                    if (p_reg == pmax)
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        p_next = p_inc;
                        j_next = jlo_inc[pasm_pkg::IDX_W-1:0];
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (!cmd_reg.valid && !dp_active)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            p_reg     <= '0;
            j_reg     <= '0;
            cmd_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            p_reg     <= p_next;
            j_reg     <= j_next;
            cmd_reg   <= cmd_next;
        end
    end

    assign busy      = state_reg != S_IDLE;
    assign cfg_ready = !busy;
    assign cmd       = cmd_reg;

    a_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_reg.valid |-> busy)
        else $error("step issued while idle");

    a_term_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PROD |-> ({1'b0, j_reg} <= da && pj <= db && {1'b0, j_reg} <= p_reg))
        else $error("product term outside both degrees");

    a_last_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_next.valid && cmd_next.last |=> state_reg == S_DRAIN)
        else $error("final product step did not lead to drain");

endmodule
`default_nettype wire

// ===== rtl/polynomial_add_sub_multiply.sv =====
`default_nettype none
// Channel        Handshake              Payload
// input word     start, busy            operation, coeff_index, coeff_value
// result word    result_valid (strobe)  result_kind, power, value, last
// configuration  cfg_valid, cfg_ready   cfg_index, cfg_data
//
// A load word is written to its store when taken and leaves busy low. A compute word holds
// busy through one step per sum and difference power, where the powers run up to the larger
// degree, and one per coefficient pair through the single multiply-accumulate, plus the
// three-stage read, multiply and add pipeline draining.
// Reset is asynchronous and active low; the coefficient stores are not cleared.
// Result words cannot be stalled: each is shown for exactly one cycle.
module polynomial_add_sub_multiply (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // Input words.
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic [1:0]                           operation,
    input  wire logic [pasm_pkg::IDX_W-1:0]           coeff_index,
    input  wire logic signed [15:0]                   coeff_value,
    // Result words.
    output logic                                      result_valid,
    output logic [1:0]                                result_kind,
    output logic [pasm_pkg::POW_W-1:0]                power,
    output logic signed [pasm_pkg::VALUE_W-1:0]       value,
    output logic                                      last,
    // Configuration writes.
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic                                 cfg_index,
    input  wire logic [3:0]                           cfg_data
);

    // The controller walks the sum, difference and product runs and issues
    // one read step per cycle; the datapath owns the stores and arithmetic.
    pasm_pkg::pasm_wr_t  wr;
    pasm_pkg::pasm_cmd_t cmd;
    logic                dp_active;

    pasm_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .operation   (operation),
        .coeff_index (coeff_index),
        .coeff_value (coeff_value),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .dp_active   (dp_active),
        .busy        (busy),
        .cfg_ready   (cfg_ready),
        .wr          (wr),
        .cmd         (cmd)
    );

    // The datapath registers every result, so each word appears on the
    // result ports for one cycle with its strobe.
    pasm_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr           (wr),
        .cmd          (cmd),
        .active       (dp_active),
        .result_valid (result_valid),
        .result_kind  (result_kind),
        .power        (power),
        .value        (value),
        .last         (last)
    );

endmodule
`default_nettype wire
